@@ rtl/sba_pkg.sv @@
// Shared constants, types and helpers for the spectrum bin averager.
// No dependencies; every other file of the block except sba_ram imports this package.
package sba_pkg;

    localparam int FFT_LENGTH      = 1024;
    localparam int HALF_LENGTH     = FFT_LENGTH / 2;
    localparam int MAX_HOPS        = 8;
    localparam int LEVEL_FRAC_BITS = 12;
    localparam int STORE_DEPTH     = 8192;
    localparam int ADDR_W          = 13;
    localparam int LEVEL_W         = 24;
    localparam int NORM_W          = 18;
    localparam int LG_W            = 20;
    localparam int LOG_STEPS       = 16;
    localparam int LOG_SHIFT       = 48 - LEVEL_FRAC_BITS;
    localparam int FIFO_DEPTH      = 32;
    localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int HAZARD_SPAN     = 4;

    localparam logic [NORM_W-1:0] NORM_RESET  = 18'd44389;
    localparam logic [16:0]       C_FAST      = 17'd58982;
    localparam logic [16:0]       C_SLOW_KEEP = 17'd64225;
    localparam logic [10:0]       C_SLOW_NEW  = 11'd1311;
    localparam logic [30:0]       LOG10_2_Q32 = 31'd1292913987;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [ADDR_W-1:0]         addr_t;

    localparam level_t LEVEL_MAX        = 24'sh7FFFFF;
    localparam level_t LEVEL_MIN        = 24'sh800000;
    localparam level_t LEVEL_INIT       = 24'(-150 * (1 << LEVEL_FRAC_BITS));
    localparam level_t LEVEL_SLOW_FLOOR = 24'(-100 * (1 << LEVEL_FRAC_BITS));

    typedef struct packed {
        level_t fast;
        level_t slow;
        level_t peak;
    } store_word_t;

    typedef struct packed {
        logic                   valid;
        logic                   zero;
        addr_t                  addr;
        logic signed [LG_W-1:0] lg;
    } lg_item_t;

    typedef struct packed {
        addr_t  addr;
        level_t fast;
        level_t slow;
        level_t peak;
    } out_word_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

    function automatic level_t sat_level(input logic signed [47:0] v);
        level_t r;
        if (v > 48'sd8388607) begin
            r = LEVEL_MAX;
        end else if (v < -48'sd8388608) begin
            r = LEVEL_MIN;
        end else begin
            r = v[LEVEL_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/sba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sba_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/sba_log.sv @@
// Power and log10 pipeline: squares, normalization, 16 squaring steps, scaling.
// Depends on sba_pkg.
module sba_log (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [31:0]          bin_real,
    input  logic signed [31:0]          bin_imag,
    input  sba_pkg::addr_t              addr,
    input  logic [sba_pkg::NORM_W-1:0]  norm_offset,
    output sba_pkg::lg_item_t           lg_item
);
    import sba_pkg::*;

    logic signed [63:0] sqr_full;
    logic signed [63:0] sqi_full;

    logic        v1_reg;
    addr_t       addr1_reg;
    logic [63:0] sqr1_reg;
    logic [63:0] sqi1_reg;

    logic        v2_reg;
    addr_t       addr2_reg;
    logic [63:0] power2_reg;

    logic        v3_reg;
    addr_t       addr3_reg;
    logic [63:0] power3_reg;
    logic [5:0]  n3_reg;
    logic        zero3_reg;
    logic [5:0]  n3_next;

    logic [63:0] shifted;

    // Squaring chain; index 0 is the normalized mantissa stage.
    logic [LOG_STEPS:0]  sv_reg;
    addr_t               saddr_reg [LOG_STEPS+1];
    logic [31:0]         m_reg     [LOG_STEPS+1];
    logic [15:0]         frac_reg  [LOG_STEPS+1];
    logic [5:0]          n_reg     [LOG_STEPS+1];
    logic                zero_reg  [LOG_STEPS+1];

    logic        vp_reg;
    addr_t       addrp_reg;
    logic        zerop_reg;
    logic [52:0] prod_reg;

    logic [53:0]            prod_rnd;
    logic [17:0]            lg_pos;
    logic signed [LG_W-1:0] lg_next;
    lg_item_t               lg_item_reg;

    assign sqr_full = bin_real * bin_real;
    assign sqi_full = bin_imag * bin_imag;

    always_comb
    begin
        n3_next = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (power2_reg[i])
            begin
                n3_next = 6'(i);
            end
        end
    end

    // Shift the leading one to bit 63; the top word is the unsigned Q1.31 mantissa.
    assign shifted = power3_reg << (6'd63 - n3_reg);

    assign prod_rnd = {1'b0, prod_reg} + (54'd1 << (LOG_SHIFT - 1));
    assign lg_pos   = prod_rnd[LOG_SHIFT +: 18];
    assign lg_next  = $signed({2'b00, lg_pos}) - $signed({2'b00, norm_offset});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            sv_reg      <= '0;
            vp_reg      <= 1'b0;
            lg_item_reg <= '0;
        end
        else
        begin
            v1_reg            <= in_valid;
            v2_reg            <= v1_reg;
            v3_reg            <= v2_reg;
            sv_reg            <= {sv_reg[LOG_STEPS-1:0], v3_reg};
            vp_reg            <= sv_reg[LOG_STEPS];
            lg_item_reg.valid <= vp_reg;
            lg_item_reg.zero  <= zerop_reg;
            lg_item_reg.addr  <= addrp_reg;
            lg_item_reg.lg    <= lg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr1_reg    <= addr;
        sqr1_reg     <= sqr_full;
        sqi1_reg     <= sqi_full;
        addr2_reg    <= addr1_reg;
        power2_reg   <= sqr1_reg + sqi1_reg;
        addr3_reg    <= addr2_reg;
        power3_reg   <= power2_reg;
        n3_reg       <= n3_next;
        zero3_reg    <= (power2_reg == 64'd0);
        saddr_reg[0] <= addr3_reg;
        m_reg[0]     <= shifted[63:32];
        frac_reg[0]  <= '0;
        n_reg[0]     <= n3_reg;
        zero_reg[0]  <= zero3_reg;
        addrp_reg    <= saddr_reg[LOG_STEPS];
        zerop_reg    <= zero_reg[LOG_STEPS];
        prod_reg     <= {n_reg[LOG_STEPS], frac_reg[LOG_STEPS]} * LOG10_2_Q32;
    end

    // One squaring per stage yields one fraction bit of log2.
    for (genvar k = 0; k < LOG_STEPS; k++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] sq_top;

        assign sq     = m_reg[k] * m_reg[k];
        assign sq_top = sq[63:31];

        always_ff @(posedge clk)
        begin
            saddr_reg[k+1] <= saddr_reg[k];
            n_reg[k+1]     <= n_reg[k];
            zero_reg[k+1]  <= zero_reg[k];
            frac_reg[k+1]  <= {frac_reg[k][14:0], sq_top[32]};
            m_reg[k+1]     <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
        end
    end

    assign lg_item = lg_item_reg;

endmodule

@@ rtl/sba_update.sv @@
// Level update pipeline: fast average, slow filter and max-hold from stored levels.
// Depends on sba_pkg; the store read data arrives in the cycle after lg_item.
module sba_update (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sba_pkg::lg_item_t    lg_item,
    input  sba_pkg::store_word_t rd_word,
    output sba_pkg::result_t     res
);
    import sba_pkg::*;

    lg_item_t           a_reg;
    logic signed [41:0] pf_a;
    logic signed [41:0] ps_a;

    logic               vb_reg;
    logic               zb_reg;
    addr_t              addrb_reg;
    logic signed [LG_W-1:0] lgb_reg;
    logic signed [41:0] pfb_reg;
    logic signed [41:0] psb_reg;
    level_t             peakb_reg;
    logic signed [47:0] fast_sum;
    level_t             fast_b;

    logic               vc_reg;
    logic               zc_reg;
    addr_t              addrc_reg;
    level_t             fastc_reg;
    logic signed [41:0] psc_reg;
    level_t             peakc_reg;
    logic signed [36:0] pn_c;

    logic               vd_reg;
    logic               zd_reg;
    addr_t              addrd_reg;
    level_t             fastd_reg;
    logic signed [41:0] psd_reg;
    logic signed [36:0] pnd_reg;
    level_t             peakd_reg;
    logic signed [47:0] slow_sum;
    level_t             slow_d;
    level_t             peak_d;

    assign pf_a = rd_word.fast * $signed({1'b0, C_FAST});
    assign ps_a = rd_word.slow * $signed({1'b0, C_SLOW_KEEP});

    assign fast_sum = ((48'(pfb_reg) + 48'sd32768) >>> 16) + 48'(lgb_reg);
    assign fast_b   = zb_reg ? LEVEL_MIN : sat_level(fast_sum);

    assign pn_c = fastc_reg * $signed({1'b0, C_SLOW_NEW});

    assign slow_sum = (48'(psd_reg) + 48'(pnd_reg) + 48'sd32768) >>> 16;

    // A zero-power bin pins the slow level to its floor and leaves max-hold alone.
    always_comb
    begin
        if (zd_reg)
        begin
            slow_d = LEVEL_SLOW_FLOOR;
            peak_d = peakd_reg;
        end
        else
        begin
            slow_d = sat_level(slow_sum);
            peak_d = ((slow_d != '0) && (slow_d > peakd_reg)) ? slow_d : peakd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= '0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            a_reg  <= lg_item;
            vb_reg <= a_reg.valid;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        zb_reg     <= a_reg.zero;
        addrb_reg  <= a_reg.addr;
        lgb_reg    <= a_reg.lg;
        pfb_reg    <= pf_a;
        psb_reg    <= ps_a;
        peakb_reg  <= rd_word.peak;
        zc_reg     <= zb_reg;
        addrc_reg  <= addrb_reg;
        fastc_reg  <= fast_b;
        psc_reg    <= psb_reg;
        peakc_reg  <= peakb_reg;
        zd_reg     <= zc_reg;
        addrd_reg  <= addrc_reg;
        fastd_reg  <= fastc_reg;
        psd_reg    <= psc_reg;
        pnd_reg    <= pn_c;
        peakd_reg  <= peakc_reg;
    end

    assign res.valid     = vd_reg;
    assign res.word.addr = addrd_reg;
    assign res.word.fast = fastd_reg;
    assign res.word.slow = slow_d;
    assign res.word.peak = peak_d;

endmodule

@@ rtl/sba_fifo.sv @@
// Output queue that holds finished results until the downstream side takes them.
// Depends on sba_pkg.
module sba_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sba_pkg::out_word_t wdata,
    input  logic               pop,
    output sba_pkg::out_word_t rdata,
    output logic               not_empty
);
    import sba_pkg::*;

    out_word_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W:0]     count_reg;
    logic [FIFO_PTR_W:0]     count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata     = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule

@@ rtl/spectrum_bin_averager_maxhold.sv @@
// Path: an accepted request passes the log pipeline, the store read, the update pipeline
// and the output queue. Throughput: one request per cycle while in_stall is low. A
// request whose store address matches one still in the hazard window waits until it has left.
// Reset: norm_offset returns to 44389 and all 8192 store rows are cleared to -150,
// one row per cycle; in_stall stays high until the last row has been written.
module spectrum_bin_averager_maxhold (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          bin_real,
    input  logic signed [31:0]          bin_imag,
    input  logic [9:0]                  bin_index,
    input  logic [2:0]                  hop_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sba_pkg::ADDR_W-1:0]  level_address,
    output logic signed [23:0]          fast_level,
    output logic signed [23:0]          slow_level,
    output logic signed [23:0]          peak_level,
    input  logic                        cfg_we,
    input  logic [sba_pkg::NORM_W-1:0]  cfg_wdata
);
    import sba_pkg::*;

    logic [10:0]  pos_sum;
    logic [10:0]  pos;
    logic [16:0]  addr_sum;
    addr_t        in_addr;
    logic         in_acc;
    logic         out_acc;
    logic         hazard;

    logic [NORM_W-1:0]       norm_reg;
    logic [FIFO_PTR_W:0]     credit_reg;
    logic [FIFO_PTR_W:0]     credit_next;
    logic                    clr_active_reg;
    addr_t                   clr_addr_reg;
    logic [HAZARD_SPAN-1:0]  hz_vld_reg;
    addr_t                   hz_addr_reg [HAZARD_SPAN];

    lg_item_t     lg_item;
    store_word_t  rd_word;
    store_word_t  wr_word;
    store_word_t  init_word;
    result_t      res;
    out_word_t    head;
    logic         ram_we;
    addr_t        ram_waddr;

    // Display position rotates the spectrum by half a length; each hop adds a further half-length offset.
    assign pos_sum  = {1'b0, bin_index} + 11'(HALF_LENGTH);
    assign pos      = (pos_sum >= 11'(FFT_LENGTH)) ? pos_sum - 11'(FFT_LENGTH) : pos_sum;
    assign addr_sum = 17'(hop_index) * 17'(HALF_LENGTH) + 17'(pos);
    assign in_addr  = addr_sum[ADDR_W-1:0];

    always_comb
    begin
        hazard = 1'b0;
        for (int i = 0; i < HAZARD_SPAN; i++)
        begin
            if (hz_vld_reg[i] && (hz_addr_reg[i] == in_addr))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign in_stall = clr_active_reg || (credit_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH)) || hazard;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;

    always_comb
    begin
        credit_next = credit_reg;
        if (in_acc && !out_acc)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg       <= NORM_RESET;
            credit_reg     <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            hz_vld_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                norm_reg <= cfg_wdata;
            end
            credit_reg <= credit_next;
            hz_vld_reg <= {hz_vld_reg[HAZARD_SPAN-2:0], in_acc};
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hz_addr_reg[0] <= in_addr;
        for (int i = 1; i < HAZARD_SPAN; i++)
        begin
            hz_addr_reg[i] <= hz_addr_reg[i-1];
        end
    end

    sba_log u_log (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_acc),
        .bin_real    (bin_real),
        .bin_imag    (bin_imag),
        .addr        (in_addr),
        .norm_offset (norm_reg),
        .lg_item     (lg_item)
    );

    assign init_word.fast = LEVEL_INIT;
    assign init_word.slow = LEVEL_INIT;
    assign init_word.peak = LEVEL_INIT;

    assign ram_we    = clr_active_reg || res.valid;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : res.word.addr;

    always_comb
    begin
        if (clr_active_reg)
        begin
            wr_word = init_word;
        end
        else
        begin
            wr_word.fast = res.word.fast;
            wr_word.slow = res.word.slow;
            wr_word.peak = res.word.peak;
        end
    end

    sba_ram #(
        .WIDTH ($bits(store_word_t)),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_word),
        .re    (lg_item.valid),
        .raddr (lg_item.addr),
        .rdata (rd_word)
    );

    sba_update u_update (
        .clk     (clk),
        .rst_n   (rst_n),
        .lg_item (lg_item),
        .rd_word (rd_word),
        .res     (res)
    );

    sba_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res.valid),
        .wdata     (res.word),
        .pop       (out_acc),
        .rdata     (head),
        .not_empty (out_valid)
    );

    assign level_address = head.addr;
    assign fast_level    = head.fast;
    assign slow_level    = head.slow;
    assign peak_level    = head.peak;

endmodule

@@ rtl/sba_checker.sv @@
// Port-level checks for the spectrum bin averager, bound to the top level.
// Depends on sba_pkg and spectrum_bin_averager_maxhold.
module sba_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic signed [31:0]          bin_real,
    input  logic signed [31:0]          bin_imag,
    input  logic [9:0]                  bin_index,
    input  logic [2:0]                  hop_index,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [sba_pkg::ADDR_W-1:0]  level_address,
    input  logic signed [23:0]          fast_level,
    input  logic signed [23:0]          slow_level,
    input  logic signed [23:0]          peak_level,
    input  logic                        cfg_we,
    input  logic [sba_pkg::NORM_W-1:0]  cfg_wdata
);
    import sba_pkg::*;

    logic [7:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Requests accepted and not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {7'd0, in_acc} - {7'd0, out_acc};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level_address)
            && $stable(fast_level) && $stable(slow_level) && $stable(peak_level))
        else $error("stalled result changed");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 8'd0)
        else $error("result without an outstanding request");

    a_peak_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slow_level != 24'sd0 && slow_level != LEVEL_SLOW_FLOOR
            |-> peak_level >= slow_level)
        else $error("max-hold below slow level");

    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("request taken during store clear");

endmodule

bind spectrum_bin_averager_maxhold sba_checker u_sba_checker (.*);
